@@ rtl/core/kwc_pkg.sv @@
// Shared constants and types for the keyword occurrence counter.
`timescale 1ns / 1ps

package kwc_pkg;

	localparam int NUM_SLOTS       = 6;
	localparam int NUM_KEYWORDS    = 6;
	localparam int MAX_KEYWORD_LEN = 8;

	localparam int KEY_W   = 64;
	localparam int LEN_W   = 4;
	localparam int LENS_W  = 24;
	localparam int HOLD_W  = 3;
	localparam int COUNT_W = 24;
	localparam int FUNC_W  = 2;
	localparam int CHAR_W  = 8;
	localparam int ADDR_W  = 6;
	localparam int DATA_W  = 64;
	localparam int REG_W   = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = 24'hFFFFFF;
	localparam logic [COUNT_W-1:0] COUNT_INIT = 24'd1;

	localparam logic [FUNC_W-1:0] FUNC_CHAR = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_EOL  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_EOT  = 2'd2;

	localparam logic [REG_W-1:0] REG_LENGTHS = 3'd6;

	typedef logic [KEY_W-1:0] keyword_t;

	typedef struct packed {
		logic char_step;
		logic line_clear;
	} step_ctl_t;

endpackage

@@ rtl/core/kwc_cfg_regs.sv @@
// APB register file holding the keywords and their lengths.
`timescale 1ns / 1ps

module kwc_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [kwc_pkg::ADDR_W-1:0]       paddr,
	input  logic [kwc_pkg::DATA_W-1:0]       pwdata,
	output logic [kwc_pkg::DATA_W-1:0]       prdata,
	output logic                             pready,
	output kwc_pkg::keyword_t                keywords [kwc_pkg::NUM_SLOTS],
	output logic [kwc_pkg::LENS_W-1:0]       keyword_lengths
);

	kwc_pkg::keyword_t                keyword_q [kwc_pkg::NUM_SLOTS];
	logic [kwc_pkg::LENS_W-1:0]       lengths_q;
	logic [kwc_pkg::REG_W-1:0]        reg_idx;
	logic                             wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[kwc_pkg::ADDR_W-1:3];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < kwc_pkg::NUM_SLOTS; i++) begin
				keyword_q[i] <= '0;
			end
			lengths_q <= '0;
		end else if (wr_en) begin
			if (reg_idx == kwc_pkg::REG_LENGTHS) begin
				lengths_q <= pwdata[kwc_pkg::LENS_W-1:0];
			end
			for (int i = 0; i < kwc_pkg::NUM_SLOTS; i++) begin
				if (reg_idx == kwc_pkg::REG_W'(i)) begin
					keyword_q[i] <= pwdata;
				end
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == kwc_pkg::REG_LENGTHS) begin
			prdata = kwc_pkg::DATA_W'(lengths_q);
		end
		for (int i = 0; i < kwc_pkg::NUM_SLOTS; i++) begin
			if (reg_idx == kwc_pkg::REG_W'(i)) begin
				prdata = keyword_q[i];
			end
		end
	end

	assign keywords        = keyword_q;
	assign keyword_lengths = lengths_q;

endmodule

@@ rtl/core/kwc_slot.sv @@
// One keyword slot: window compare and the non-overlap hold-off counter.
`timescale 1ns / 1ps

module kwc_slot #(
	parameter int MAX_KEYWORD_LEN = kwc_pkg::MAX_KEYWORD_LEN,
	parameter int FILL_W          = $clog2(MAX_KEYWORD_LEN + 1)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  kwc_pkg::step_ctl_t             ctl,
	input  logic [8*MAX_KEYWORD_LEN-1:0]   window,
	input  logic [FILL_W-1:0]              fill,
	input  kwc_pkg::keyword_t              keyword,
	input  logic [kwc_pkg::LEN_W-1:0]      len_raw,
	output logic                           hit
);

	logic [kwc_pkg::LEN_W-1:0]  len;
	logic [kwc_pkg::HOLD_W-1:0] hold_q;
	logic                       bytes_ok;
	logic                       match;

	assign len = (len_raw > kwc_pkg::LEN_W'(MAX_KEYWORD_LEN)) ?
		kwc_pkg::LEN_W'(MAX_KEYWORD_LEN) : len_raw;

	// The first keyword byte lines up with the oldest of the last len window bytes.
	always_comb begin
		bytes_ok = 1'b1;
		for (int b = 0; b < MAX_KEYWORD_LEN; b++) begin
			if (kwc_pkg::LEN_W'(b) < len) begin
				if (keyword[8*b +: 8] !=
					window[8*(len - kwc_pkg::LEN_W'(b) - kwc_pkg::LEN_W'(1)) +: 8]) begin
					bytes_ok = 1'b0;
				end
			end
		end
	end

	assign match = (hold_q == '0) && (len != '0) &&
		(kwc_pkg::LEN_W'(fill) >= len) && bytes_ok;
	assign hit   = ctl.char_step && match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
		end else if (ctl.line_clear) begin
			hold_q <= '0;
		end else if (ctl.char_step) begin
			if (hold_q != '0) begin
				hold_q <= hold_q - kwc_pkg::HOLD_W'(1);
			end else if (match) begin
				hold_q <= kwc_pkg::HOLD_W'(len - kwc_pkg::LEN_W'(1));
			end
		end
	end

endmodule

@@ rtl/core/keyword_occurrence_counter_top.sv @@
// Top level of the keyword occurrence counter: input stage, line window, count and result.
//
// Text requests arrive on the text channel (func, character) under text_valid and
// text_stall; a request is taken at a rising edge with text_valid high and text_stall
// low. A character request shifts the byte into the line window and adds one to the
// count for every configured keyword that ends there and is not held off by an earlier
// match of itself. End of line clears the window and the hold-off counters.
// End of text also produces one result (complexity, overflow) on the result channel,
// then returns the count to 1 and clears the overflow flag.
// One request is taken every cycle while text_stall is low. A request is registered in
// the input stage at acceptance and processed from there; an end-of-text result is
// registered in the result register and shows on result_valid.
// While the result register holds an untaken result and result_stall is high, an
// end-of-text request waiting in the input stage holds and text_stall is raised;
// other requests keep flowing.
// Reset clears the keywords, lengths, line state and result_valid and sets the count to 1.
// The user writes keywords through APB only while idle; the block does not check it.
`timescale 1ns / 1ps

module keyword_occurrence_counter_top #(
	parameter int NUM_KEYWORDS    = kwc_pkg::NUM_KEYWORDS,
	parameter int MAX_KEYWORD_LEN = kwc_pkg::MAX_KEYWORD_LEN
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kwc_pkg::ADDR_W-1:0]    paddr,
	input  logic [kwc_pkg::DATA_W-1:0]    pwdata,
	output logic [kwc_pkg::DATA_W-1:0]    prdata,
	output logic                          pready,
	input  logic                          text_valid,
	output logic                          text_stall,
	input  logic [kwc_pkg::FUNC_W-1:0]    func,
	input  logic [kwc_pkg::CHAR_W-1:0]    character,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [kwc_pkg::COUNT_W-1:0]   complexity,
	output logic                          overflow
);

	localparam int WIN_W  = 8 * MAX_KEYWORD_LEN;
	localparam int FILL_W = $clog2(MAX_KEYWORD_LEN + 1);
	localparam int HITS_W = $clog2(NUM_KEYWORDS + 1);

	kwc_pkg::keyword_t               keywords [kwc_pkg::NUM_SLOTS];
	logic [kwc_pkg::LENS_W-1:0]      keyword_lengths;

	logic                            valid_s1;
	logic [kwc_pkg::FUNC_W-1:0]      func_s1;
	logic [kwc_pkg::CHAR_W-1:0]      char_s1;

	logic [WIN_W-1:0]                window_q;
	logic [FILL_W-1:0]               fill_q;
	logic [kwc_pkg::COUNT_W-1:0]     count_q;
	logic                            ovf_q;
	logic                            result_valid_q;
	logic [kwc_pkg::COUNT_W-1:0]     complexity_q;
	logic                            overflow_q;

	logic                            proc;
	logic                            do_char;
	logic                            do_eol;
	logic                            do_eot;
	kwc_pkg::step_ctl_t              ctl;
	logic [WIN_W-1:0]                window_next;
	logic [FILL_W-1:0]               fill_next;
	logic [NUM_KEYWORDS-1:0]         hits;
	logic [HITS_W-1:0]               num_hits;
	logic [kwc_pkg::COUNT_W:0]       sum;
	logic                            sat;

	kwc_cfg_regs u_cfg (
		.clk             (clk),
		.arst_n          (arst_n),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready),
		.keywords        (keywords),
		.keyword_lengths (keyword_lengths)
	);

	assign text_stall = valid_s1 && (func_s1 == kwc_pkg::FUNC_EOT) &&
		result_valid_q && result_stall;
	assign proc    = valid_s1 && !text_stall;
	assign do_char = proc && (func_s1 == kwc_pkg::FUNC_CHAR);
	assign do_eol  = proc && (func_s1 == kwc_pkg::FUNC_EOL);
	assign do_eot  = proc && (func_s1 == kwc_pkg::FUNC_EOT);

	assign ctl.char_step  = do_char;
	assign ctl.line_clear = do_eol || do_eot;

	assign window_next = (window_q << 8) | WIN_W'(char_s1);
	assign fill_next   = (fill_q < FILL_W'(MAX_KEYWORD_LEN)) ? fill_q + FILL_W'(1) : fill_q;

	for (genvar k = 0; k < NUM_KEYWORDS; k++) begin : g_slot
		kwc_slot #(
			.MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
			.FILL_W          (FILL_W)
		) u_slot (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.window  (window_next),
			.fill    (fill_next),
			.keyword (keywords[k]),
			.len_raw (keyword_lengths[kwc_pkg::LEN_W*k +: kwc_pkg::LEN_W]),
			.hit     (hits[k])
		);
	end

	always_comb begin
		num_hits = '0;
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			num_hits = num_hits + HITS_W'(hits[k]);
		end
	end

	assign sum = {1'b0, count_q} + (kwc_pkg::COUNT_W + 1)'(num_hits);
	assign sat = sum >= {1'b0, kwc_pkg::COUNT_MAX};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			func_s1 <= func;
			char_s1 <= character;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			fill_q   <= '0;
		end else if (do_eol || do_eot) begin
			window_q <= '0;
			fill_q   <= '0;
		end else if (do_char) begin
			window_q <= window_next;
			fill_q   <= fill_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= kwc_pkg::COUNT_INIT;
			ovf_q   <= 1'b0;
		end else if (do_eot) begin
			count_q <= kwc_pkg::COUNT_INIT;
			ovf_q   <= 1'b0;
		end else if (do_char && (num_hits != '0)) begin
			count_q <= sat ? kwc_pkg::COUNT_MAX : sum[kwc_pkg::COUNT_W-1:0];
			ovf_q   <= ovf_q || sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (do_eot) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_eot) begin
			complexity_q <= count_q;
			overflow_q   <= ovf_q;
		end
	end

	assign result_valid = result_valid_q;
	assign complexity   = complexity_q;
	assign overflow     = overflow_q;

	a_count_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0)
		else $error("Running count dropped to zero.");

	a_ovf_at_max : assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (count_q == kwc_pkg::COUNT_MAX))
		else $error("Overflow flag set while the count is below saturation.");

	a_eot_restart : assert property (@(posedge clk) disable iff (!arst_n)
		do_eot |=> (count_q == kwc_pkg::COUNT_INIT) && !ovf_q && (fill_q == '0))
		else $error("End of text did not restart the count and line state.");

	a_fill_bound : assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(MAX_KEYWORD_LEN))
		else $error("Window fill exceeds the longest keyword.");

	a_stall_cause : assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> valid_s1 && (func_s1 == kwc_pkg::FUNC_EOT) && result_valid_q)
		else $error("Input stalled without a pending end-of-text request.");

endmodule
